/* rtl/sdspi_pkg.sv */
// Shared types, codes and packet helpers for the SD SPI-mode command engine.
package sdspi_pkg;

    localparam logic [1:0] FUNC_ISSUE = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic CFG_READY_TIMEOUT = 1'b0;
    localparam logic CFG_RESP_ATTEMPTS = 1'b1;

    localparam logic [7:0] READY_TIMEOUT_RST = 8'd50;
    localparam logic [3:0] RESP_ATTEMPTS_RST = 4'd10;

    localparam logic [7:0] BYTE_DUMMY    = 8'hFF;
    localparam logic [7:0] CMD_START     = 8'h40;
    localparam logic [7:0] CRC_CMD0      = 8'h95;
    localparam logic [7:0] CRC_CMD8      = 8'h87;
    localparam logic [7:0] CRC_OTHER     = 8'h01;
    localparam logic [5:0] IDX_GO_IDLE   = 6'd0;
    localparam logic [5:0] IDX_SEND_IF   = 6'd8;
    localparam logic [5:0] IDX_STOP      = 6'd12;
    localparam logic [5:0] IDX_APP_CMD   = 6'd55;
    localparam logic [2:0] POS_CRC       = 3'd5;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_DESEL    = 8'b0000_0010,
        PH_SELDUMMY = 8'b0000_0100,
        PH_WAIT     = 8'b0000_1000,
        PH_CMD      = 8'b0001_0000,
        PH_STUFF    = 8'b0010_0000,
        PH_RESP     = 8'b0100_0000,
        PH_FAILDESEL = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  cmd_index;
        logic        app_command;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select_active;
        logic       done_res;
        logic [7:0] response;
    } t_result;

    // One byte of the six-byte command frame, position 0 is the start byte.
    function automatic logic [7:0] packet_byte(input logic [2:0] pos,
                                               input logic [5:0] idx,
                                               input logic [31:0] arg);
        logic [7:0] b;
        case (pos)
            3'd0: b = CMD_START | {2'b00, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: begin
                if (idx == IDX_GO_IDLE) b = CRC_CMD0;
                else if (idx == IDX_SEND_IF) b = CRC_CMD8;
                else b = CRC_OTHER;
            end
        endcase
        return b;
    endfunction

endpackage

/* rtl/sdspi_in_stage.sv */
// Input register stage that holds one accepted beat until the sequencer takes it.
module sdspi_in_stage import sdspi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/sdspi_seq.sv */
// Command sequencer state and the single-pass next-state and result logic.
module sdspi_seq import sdspi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item      i_item,
    input  logic [7:0] i_ready_timeout,
    input  logic [3:0] i_resp_attempts,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_byte_pos, n_byte_pos;
    logic [5:0]  r_held_index, n_held_index;
    logic [31:0] r_held_arg, n_held_arg;
    logic        r_prefix, n_prefix;
    logic [7:0]  r_ready_timer, n_ready_timer;
    logic [3:0]  r_attempts, n_attempts;
    logic        r_select, n_select;

    logic [5:0]  cur_index;
    logic [31:0] cur_arg;
    logic        txv, done;
    logic [7:0]  txb, resp;

    assign cur_index = r_prefix ? IDX_APP_CMD : r_held_index;
    assign cur_arg   = r_prefix ? 32'd0 : r_held_arg;

    always_comb begin
        n_phase       = r_phase;
        n_byte_pos    = r_byte_pos;
        n_held_index  = r_held_index;
        n_held_arg    = r_held_arg;
        n_prefix      = r_prefix;
        n_ready_timer = r_ready_timer;
        n_attempts    = r_attempts;
        n_select      = r_select;
        txv  = 1'b0;
        txb  = 8'd0;
        done = 1'b0;
        resp = 8'd0;
        if (i_item.func == FUNC_TICK) begin
            if (r_ready_timer != 8'd0) n_ready_timer = r_ready_timer - 8'd1;
        end else if (i_item.func == FUNC_ISSUE) begin
            if (r_phase == PH_IDLE) begin
                n_held_index = i_item.cmd_index;
                n_prefix     = i_item.app_command;
                n_held_arg   = i_item.argument;
                n_select     = 1'b0;
                txv = 1'b1; txb = BYTE_DUMMY;
                n_phase = PH_DESEL;
            end
        end else if (i_item.func == FUNC_RX) begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_DESEL: begin
                    n_select = 1'b1;
                    txv = 1'b1; txb = BYTE_DUMMY;
                    n_phase = PH_SELDUMMY;
                end
                PH_SELDUMMY: begin
                    n_ready_timer = i_ready_timeout;
                    txv = 1'b1; txb = BYTE_DUMMY;
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    txv = 1'b1;
                    if (i_item.rx_byte == BYTE_DUMMY) begin
                        n_byte_pos = 3'd0;
                        txb = packet_byte(3'd0, cur_index, cur_arg);
                        n_phase = PH_CMD;
                    end else if (r_ready_timer == 8'd0) begin
                        n_select = 1'b0;
                        txb = BYTE_DUMMY;
                        n_phase = PH_FAILDESEL;
                    end else begin
                        txb = BYTE_DUMMY;
                    end
                end
                PH_CMD: begin
                    txv = 1'b1;
                    if (r_byte_pos < POS_CRC) begin
                        n_byte_pos = r_byte_pos + 3'd1;
                        txb = packet_byte(r_byte_pos + 3'd1, cur_index, cur_arg);
                    end else begin
                        n_byte_pos = 3'd0;
                        txb = BYTE_DUMMY;
                        if (cur_index == IDX_STOP) begin
                            n_phase = PH_STUFF;
                        end else begin
                            n_attempts = i_resp_attempts;
                            n_phase = PH_RESP;
                        end
                    end
                end
                PH_STUFF: begin
                    n_attempts = i_resp_attempts;
                    txv = 1'b1; txb = BYTE_DUMMY;
                    n_phase = PH_RESP;
                end
                PH_RESP: begin
                    if (i_item.rx_byte[7] && r_attempts > 4'd1) begin
                        n_attempts = r_attempts - 4'd1;
                        txv = 1'b1; txb = BYTE_DUMMY;
                    end else begin
                        n_attempts = 4'd0;
                        n_prefix   = 1'b0;
                        if (r_prefix && i_item.rx_byte <= 8'd1) begin
                            // CMD55 accepted: go on with the real command.
                            n_select = 1'b0;
                            txv = 1'b1; txb = BYTE_DUMMY;
                            n_phase = PH_DESEL;
                        end else begin
                            done = 1'b1; resp = i_item.rx_byte;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_FAILDESEL: begin
                    n_prefix = 1'b0;
                    done = 1'b1; resp = BYTE_DUMMY;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        o_result.tx_valid           = txv;
        o_result.tx_byte            = txb;
        o_result.chip_select_active = n_select;
        o_result.done_res           = done;
        o_result.response           = resp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_byte_pos    <= 3'd0;
            r_held_index  <= 6'd0;
            r_held_arg    <= 32'd0;
            r_prefix      <= 1'b0;
            r_ready_timer <= 8'd0;
            r_attempts    <= 4'd0;
            r_select      <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_byte_pos    <= n_byte_pos;
            r_held_index  <= n_held_index;
            r_held_arg    <= n_held_arg;
            r_prefix      <= n_prefix;
            r_ready_timer <= n_ready_timer;
            r_attempts    <= n_attempts;
            r_select      <= n_select;
        end
    end

endmodule

/* rtl/sdspi_out_stage.sv */
// Result register that holds one result beat until the consumer takes it.
module sdspi_out_stage import sdspi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/sd_spi_command_engine_core.sv */
// Top level of the SD SPI-mode command engine: input stage, sequencer, result register.
//
//  Channel   Handshake                  Direction  Beat contents
//  in        i_in_valid / o_in_ready    input      func, cmd_index, app_command,
//                                                  argument, rx_byte
//  out       o_out_valid / i_out_ready  output     tx_valid, tx_byte,
//                                                  chip_select_active, done_res, response
//  cfg       i_cfg_we                   input      i_cfg_index, i_cfg_data
//
// Every input beat yields exactly one result beat. A beat accepted into the input
// register is evaluated by the sequencer once the result register is free, and its
// result is registered there. One beat per cycle sustained while i_out_ready stays high.
// Only the consumer slows the flow: with the result register full and i_out_ready low,
// the sequencer holds, the input register fills and o_in_ready drops.
// Reset is synchronous and active low; it empties both registers, idles the sequencer
// with the card deselected and loads the default timeouts.
module sd_spi_command_engine_core import sdspi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_cmd_index,
    input  logic        i_app_command,
    input  logic [31:0] i_argument,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_chip_select_active,
    output logic        o_done_res,
    output logic [7:0]  o_response,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_item   in_item, held_item;
    t_result seq_result, out_result;
    logic    held_valid, out_free, step;

    logic [7:0] r_ready_timeout;
    logic [3:0] r_resp_attempts;

    // Config registers. User must change them only while the engine is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_timeout <= READY_TIMEOUT_RST;
            r_resp_attempts <= RESP_ATTEMPTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_READY_TIMEOUT: r_ready_timeout <= i_cfg_data;
                CFG_RESP_ATTEMPTS: r_resp_attempts <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.func        = i_func;
    assign in_item.cmd_index   = i_cmd_index;
    assign in_item.app_command = i_app_command;
    assign in_item.argument    = i_argument;
    assign in_item.rx_byte     = i_rx_byte;

    // The sequencer advances on a held beat whenever the result register can take it.
    assign step = held_valid && out_free;

    sdspi_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    sdspi_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (held_item),
        .i_ready_timeout (r_ready_timeout),
        .i_resp_attempts (r_resp_attempts),
        .o_result        (seq_result)
    );

    sdspi_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (seq_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_tx_valid           = out_result.tx_valid;
    assign o_tx_byte            = out_result.tx_byte;
    assign o_chip_select_active = out_result.chip_select_active;
    assign o_done_res           = out_result.done_res;
    assign o_response           = out_result.response;

    // A finished command never starts another exchange in the same beat.
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_tx_valid)
        else $error("done beat also requests an exchange");

    // Idle bytes and responses are zero when their flag is low.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_tx_valid || o_tx_byte == 8'd0) &&
                         (o_done_res || o_response == 8'd0)))
        else $error("payload field set without its flag");

    // A held input beat is never dropped while the result side stalls.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !step) |=> held_valid)
        else $error("input beat lost during stall");

    // A result that was not taken stays in place.
    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(out_result)))
        else $error("result beat changed during stall");

endmodule

/* tb/sdspi_sequence_checker.sv */
// Scoreboard for the SD SPI command engine: predicts each result beat and compares it.
`timescale 1ns / 100ps

module sdspi_sequence_checker import sdspi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_cmd_index,
    input  logic        i_app_command,
    input  logic [31:0] i_argument,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_tx_valid,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_chip_select_active,
    input  logic        i_done_res,
    input  logic [7:0]  i_response,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);

    // Shadow copy of the timeout registers.
    logic [7:0] timeout_ticks;
    logic [3:0] attempt_limit;

    // Shadow copy of the sequencer.
    t_phase      seq_phase;
    logic [2:0]  frame_pos;
    logic [5:0]  held_idx;
    logic [31:0] held_arg;
    logic        acmd_prefix;
    logic [7:0]  ready_timer;
    logic [3:0]  attempts_left;
    logic        cs_driven;

    t_result predicted_replies[$];
    int      fail_count = 0;

    // While the CMD55 prefix runs, the frame carries index 55 and a zero argument.
    function automatic logic [5:0] active_index();
        return acmd_prefix ? IDX_APP_CMD : held_idx;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [2:0] pos);
        logic [31:0] arg;
        logic [5:0]  idx;
        arg = acmd_prefix ? 32'd0 : held_arg;
        idx = active_index();
        case (pos)
            3'd0: return CMD_START | {2'b00, idx};
            3'd1: return arg[31:24];
            3'd2: return arg[23:16];
            3'd3: return arg[15:8];
            3'd4: return arg[7:0];
            default: begin
                if (idx == IDX_GO_IDLE) return CRC_CMD0;
                else if (idx == IDX_SEND_IF) return CRC_CMD8;
                else return CRC_OTHER;
            end
        endcase
    endfunction

    function automatic t_result advance_sequencer(input t_item beat);
        t_result r;
        r = '0;
        case (beat.func)
            FUNC_TICK: begin
                if (ready_timer != 8'd0) ready_timer = ready_timer - 8'd1;
            end
            FUNC_ISSUE: begin
                if (seq_phase == PH_IDLE) begin
                    held_idx    = beat.cmd_index;
                    acmd_prefix = beat.app_command;
                    held_arg    = beat.argument;
                    cs_driven   = 1'b0;
                    r.tx_valid  = 1'b1;
                    r.tx_byte   = BYTE_DUMMY;
                    seq_phase   = PH_DESEL;
                end
            end
            FUNC_RX: begin
                case (seq_phase)
                    PH_DESEL: begin
                        cs_driven  = 1'b1;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = BYTE_DUMMY;
                        seq_phase  = PH_SELDUMMY;
                    end
                    PH_SELDUMMY: begin
                        ready_timer = timeout_ticks;
                        r.tx_valid  = 1'b1;
                        r.tx_byte   = BYTE_DUMMY;
                        seq_phase   = PH_WAIT;
                    end
                    PH_WAIT: begin
                        r.tx_valid = 1'b1;
                        if (beat.rx_byte == BYTE_DUMMY) begin
                            frame_pos = 3'd0;
                            r.tx_byte = frame_byte(3'd0);
                            seq_phase = PH_CMD;
                        end else if (ready_timer == 8'd0) begin
                            cs_driven = 1'b0;
                            r.tx_byte = BYTE_DUMMY;
                            seq_phase = PH_FAILDESEL;
                        end else begin
                            r.tx_byte = BYTE_DUMMY;
                        end
                    end
                    PH_CMD: begin
                        r.tx_valid = 1'b1;
                        if (frame_pos < POS_CRC) begin
                            frame_pos = frame_pos + 3'd1;
                            r.tx_byte = frame_byte(frame_pos);
                        end else begin
                            frame_pos = 3'd0;
                            r.tx_byte = BYTE_DUMMY;
                            if (active_index() == IDX_STOP) begin
                                seq_phase = PH_STUFF;
                            end else begin
                                attempts_left = attempt_limit;
                                seq_phase     = PH_RESP;
                            end
                        end
                    end
                    PH_STUFF: begin
                        attempts_left = attempt_limit;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = BYTE_DUMMY;
                        seq_phase     = PH_RESP;
                    end
                    PH_RESP: begin
                        if (beat.rx_byte[7] && attempts_left > 4'd1) begin
                            attempts_left = attempts_left - 4'd1;
                            r.tx_valid    = 1'b1;
                            r.tx_byte     = BYTE_DUMMY;
                        end else begin
                            attempts_left = 4'd0;
                            if (acmd_prefix && beat.rx_byte <= 8'd1) begin
                                // CMD55 accepted: go on with the real command.
                                acmd_prefix = 1'b0;
                                cs_driven   = 1'b0;
                                r.tx_valid  = 1'b1;
                                r.tx_byte   = BYTE_DUMMY;
                                seq_phase   = PH_DESEL;
                            end else begin
                                acmd_prefix = 1'b0;
                                r.done_res  = 1'b1;
                                r.response  = beat.rx_byte;
                                seq_phase   = PH_IDLE;
                            end
                        end
                    end
                    PH_FAILDESEL: begin
                        acmd_prefix = 1'b0;
                        r.done_res  = 1'b1;
                        r.response  = BYTE_DUMMY;
                        seq_phase   = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        r.chip_select_active = cs_driven;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   beat_in;
        t_result want;
        if (!i_rst_n) begin
            timeout_ticks = READY_TIMEOUT_RST;
            attempt_limit = RESP_ATTEMPTS_RST;
            seq_phase     = PH_IDLE;
            frame_pos     = 3'd0;
            held_idx      = 6'd0;
            held_arg      = 32'd0;
            acmd_prefix   = 1'b0;
            ready_timer   = 8'd0;
            attempts_left = 4'd0;
            cs_driven     = 1'b0;
            predicted_replies.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_READY_TIMEOUT) timeout_ticks = i_cfg_data;
                else attempt_limit = i_cfg_data[3:0];
            end
            // Results first, so a beat taken at this same edge cannot hide an extra result.
            if (i_out_valid && i_out_ready) begin
                if (predicted_replies.size() == 0) begin
                    $error("result beat with no prediction waiting (tx_byte 0x%02h)",
                           i_tx_byte);
                    fail_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, i_tx_valid});
                    check_field("tx_byte", want.tx_byte, i_tx_byte);
                    check_field("chip_select_active", {7'd0, want.chip_select_active},
                                {7'd0, i_chip_select_active});
                    check_field("done_res", {7'd0, want.done_res}, {7'd0, i_done_res});
                    check_field("response", want.response, i_response);
                end
            end
            if (i_in_valid && i_in_ready) begin
                beat_in.func        = i_func;
                beat_in.cmd_index   = i_cmd_index;
                beat_in.app_command = i_app_command;
                beat_in.argument    = i_argument;
                beat_in.rx_byte     = i_rx_byte;
                predicted_replies.push_back(advance_sequencer(beat_in));
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= predicted_replies.size();
    end

endmodule

/* tb/tb_sd_spi_command_engine_core.sv */
// Top of the SD SPI command engine testbench: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps

module tb_sd_spi_command_engine_core;
    import sdspi_pkg::*;

    // func value the engine has no use for; it must pass through as a no-op beat.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int          NUM_PHASES       = 6;
    localparam int unsigned BEATS_PER_PHASE  = 265;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT      = 5000;
    localparam int          SETTLE_CYCLES    = 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_func        = FUNC_ISSUE;
    logic [5:0]  i_cmd_index   = 6'd0;
    logic        i_app_command = 1'b0;
    logic [31:0] i_argument    = 32'd0;
    logic [7:0]  i_rx_byte     = 8'd0;
    logic        i_out_ready   = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_READY_TIMEOUT;
    logic [7:0]  i_cfg_data    = 8'd0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_chip_select_active;
    logic        o_done_res;
    logic [7:0]  o_response;

    int fail_count;
    int outstanding;

    // Set by the stimulus to ask the result sink for one long hold-off.
    bit long_hold_req = 1'b0;

    // Sender burst bookkeeping and the count of meaningful beats sent so far.
    int unsigned burst_left = 0;
    int unsigned beats_sent = 0;

    // The stimulus keeps its own view of the timeouts so that it can steer a command
    // into the ready timeout or keep it clear of it.
    logic [7:0]  cur_ready_ticks = READY_TIMEOUT_RST;
    int unsigned cur_attempts    = RESP_ATTEMPTS_RST;

    // Timeout settings per phase; phase 0 keeps the reset values. The attempts byte
    // carries junk in its upper nibble on purpose, and one phase writes zero attempts.
    logic [7:0] phase_ticks    [NUM_PHASES] = '{8'd50, 8'd1, 8'd255, 8'd0, 8'd12, 8'd3};
    logic [7:0] phase_attempts [NUM_PHASES] = '{8'h0A, 8'h01, 8'hFF, 8'hF0, 8'h35, 8'h9E};

    sd_spi_command_engine_core i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_func               (i_func),
        .i_cmd_index          (i_cmd_index),
        .i_app_command        (i_app_command),
        .i_argument           (i_argument),
        .i_rx_byte            (i_rx_byte),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_tx_valid           (o_tx_valid),
        .o_tx_byte            (o_tx_byte),
        .o_chip_select_active (o_chip_select_active),
        .o_done_res           (o_done_res),
        .o_response           (o_response),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    sdspi_sequence_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_func               (i_func),
        .i_cmd_index          (i_cmd_index),
        .i_app_command        (i_app_command),
        .i_argument           (i_argument),
        .i_rx_byte            (i_rx_byte),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_tx_valid           (o_tx_valid),
        .i_tx_byte            (o_tx_byte),
        .i_chip_select_active (o_chip_select_active),
        .i_done_res           (o_done_res),
        .i_response           (o_response),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_fail_count         (fail_count),
        .o_outstanding        (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run, including every long hold-off and
    // the few ready timeouts that burn through 255 ticks.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result sink. It switches between stretches of its own: always ready, coin-flip
    // ready, a short on/off pattern, and mostly stalled. When the stimulus asks, it
    // holds ready low for a long count so that the input side backs up.
    initial begin : result_sink
        int unsigned span;
        int unsigned period;
        int unsigned k;
        int          mode;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                repeat (LONG_HOLD_CYCLES) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
                long_hold_req = 1'b0;
            end else begin
                mode   = $urandom_range(0, 3);
                span   = $urandom_range(4, 40);
                period = $urandom_range(2, 5);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= 1'($urandom);
                        2: i_out_ready <= ((k % period) != 0);
                        default: i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offers one beat and returns at the edge where it is taken. The sender works in
    // bursts; when a burst runs out it drops valid for a random gap first. Within a
    // burst valid stays high from one beat to the next without a dip.
    task automatic send_beat(input logic [1:0] func, input logic [5:0] idx,
                             input logic app, input logic [31:0] arg,
                             input logic [7:0] rx, input bit counted);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_cmd_index   <= idx;
        i_app_command <= app;
        i_argument    <= arg;
        i_rx_byte     <= rx;
        do @(posedge i_clk); while (!o_in_ready);
        if (counted) beats_sent++;
    endtask

    // Received-byte beat; the fields that the engine ignores here carry random bits.
    task automatic rx_beat(input logic [7:0] rx);
        send_beat(FUNC_RX, 6'($urandom), 1'($urandom), $urandom, rx, 1'b1);
    endtask

    task automatic tick_beat();
        send_beat(FUNC_TICK, 6'($urandom), 1'($urandom), $urandom, 8'($urandom), 1'b1);
    endtask

    // A beat that changes nothing but perhaps the ready timer: the unused func, a tick,
    // and either an issue while a command runs or a received byte while idle.
    task automatic noise_beat(input bit busy);
        case ($urandom_range(0, 2))
            0: send_beat(FUNC_UNUSED, 6'($urandom), 1'($urandom), $urandom,
                         8'($urandom), 1'b0);
            1: send_beat(busy ? FUNC_ISSUE : FUNC_RX, 6'($urandom), 1'($urandom),
                         $urandom, 8'($urandom), 1'b0);
            default: send_beat(FUNC_TICK, 6'($urandom), 1'($urandom), $urandom,
                               8'($urandom), 1'b0);
        endcase
    endtask

    // Only called outside the ready wait, where a stray tick cannot change the outcome.
    task automatic maybe_noise();
        if ($urandom_range(0, 7) == 0) noise_beat(1'b1);
    endtask

    // Plays the card side of one command on the bus: the two select dummies, the
    // ready wait, the six frame bytes, the stuff byte after CMD12 and the R1 poll.
    // finished comes back low only when a CMD55 prefix was accepted and the real
    // command follows.
    task automatic run_leg(input logic [5:0] idx, input bit prefix, output bit finished);
        int unsigned ticks_used;
        int unsigned busy_bytes;
        int          n;
        bit          give_up;
        logic [7:0]  r1;
        finished = 1'b1;
        rx_beat(8'($urandom));
        maybe_noise();
        rx_beat(8'($urandom));
        // From here the ready timer counts down from the programmed value on each tick.
        ticks_used = 0;
        if (cur_ready_ticks <= 8'd16) give_up = ($urandom_range(0, 3) == 0);
        else give_up = ($urandom_range(0, 31) == 0);
        if (give_up) begin
            // Card stays busy until the timer has run out; the next busy byte then
            // releases chip select and the command ends with 0xFF.
            n = $urandom_range(0, 2);
            repeat (n) begin
                if (ticks_used < cur_ready_ticks) rx_beat(8'($urandom_range(0, 254)));
                tick_beat();
                ticks_used++;
            end
            while (ticks_used < cur_ready_ticks) begin
                tick_beat();
                ticks_used++;
            end
            rx_beat(8'($urandom_range(0, 254)));
            maybe_noise();
            rx_beat(8'($urandom));
            return;
        end
        // Card is busy for a few bytes, but the timer never reaches zero before 0xFF.
        n = (cur_ready_ticks == 8'd0) ? 0 : $urandom_range(0, 4);
        repeat (n) begin
            if (ticks_used + 1 < cur_ready_ticks && $urandom_range(0, 1) == 1) begin
                tick_beat();
                ticks_used++;
            end
            rx_beat(8'($urandom_range(0, 254)));
        end
        rx_beat(BYTE_DUMMY);
        repeat (6) begin
            maybe_noise();
            rx_beat(8'($urandom));
        end
        if (idx == IDX_STOP) rx_beat(8'($urandom));
        // R1 poll: some bytes with bit 7 set, then the answer. On the last attempt the
        // answer may itself have bit 7 set and is reported as it is.
        busy_bytes = $urandom_range(0, cur_attempts - 1);
        repeat (busy_bytes) rx_beat(8'($urandom_range(128, 255)));
        if (busy_bytes == cur_attempts - 1 && $urandom_range(0, 2) == 0)
            r1 = 8'($urandom_range(128, 255));
        else if (prefix && $urandom_range(0, 3) != 0)
            r1 = 8'($urandom_range(0, 1));
        else
            r1 = 8'($urandom_range(0, 127));
        rx_beat(r1);
        finished = !(prefix && r1 <= 8'd1);
    endtask

    task automatic run_command(input logic [5:0] idx, input bit app,
                               input logic [31:0] arg);
        bit finished;
        send_beat(FUNC_ISSUE, idx, app, arg, 8'($urandom), 1'b1);
        maybe_noise();
        if (app) begin
            run_leg(IDX_APP_CMD, 1'b1, finished);
            if (finished) return;
        end
        run_leg(idx, 1'b0, finished);
    endtask

    // Stops offering beats and waits until every predicted result has been taken.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Both registers, back to back, only while the engine is idle.
    task automatic write_timeouts(input logic [7:0] ticks, input logic [7:0] attempts_raw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_READY_TIMEOUT;
        i_cfg_data  <= ticks;
        @(posedge i_clk);
        i_cfg_index <= CFG_RESP_ATTEMPTS;
        i_cfg_data  <= attempts_raw;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_ready_ticks = ticks;
        // A zero attempt count behaves like a single attempt.
        cur_attempts = (attempts_raw[3:0] == 4'd0) ? 1 : attempts_raw[3:0];
    endtask

    initial begin : stimulus
        int          p;
        int unsigned phase_end;
        int unsigned waited;
        bit          halfway_done;
        bit          finished;
        bit          app;
        logic [5:0]  idx;
        logic [31:0] arg;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: beats the idle engine must ignore, then CMD12 with an
        // all-ones argument and an issue thrown in while it is busy.
        send_beat(FUNC_RX, 6'h3F, 1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0);
        send_beat(FUNC_UNUSED, 6'h00, 1'b0, 32'h0000_0000, 8'hFF, 1'b0);
        send_beat(FUNC_TICK, 6'h2A, 1'b1, 32'h5555_AAAA, 8'h80, 1'b0);
        send_beat(FUNC_ISSUE, IDX_STOP, 1'b0, 32'hFFFF_FFFF, 8'h00, 1'b1);
        send_beat(FUNC_ISSUE, 6'h3F, 1'b1, 32'h0000_0000, 8'hFF, 1'b0);
        run_leg(IDX_STOP, 1'b0, finished);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_for_results();
                write_timeouts(phase_ticks[p], phase_attempts[p]);
            end
            phase_end    = beats_sent + BEATS_PER_PHASE;
            halfway_done = 1'b0;
            while (beats_sent < phase_end) begin
                // Halfway through, either starve the output for a long stretch while
                // beats keep coming, or stop sending until everything has drained.
                if (!halfway_done && beats_sent + BEATS_PER_PHASE / 2 >= phase_end) begin
                    halfway_done = 1'b1;
                    if (p % 2 == 0) long_hold_req = 1'b1;
                    else wait_for_results();
                end
                case ($urandom_range(0, 7))
                    0: idx = IDX_GO_IDLE;
                    1: idx = IDX_SEND_IF;
                    2: idx = IDX_STOP;
                    3: idx = IDX_APP_CMD;
                    4: idx = 6'h3F;
                    default: idx = 6'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: arg = 32'h0000_0000;
                    1: arg = 32'hFFFF_FFFF;
                    default: arg = $urandom;
                endcase
                app = ($urandom_range(0, 2) == 0);
                run_command(idx, app, arg);
                if ($urandom_range(0, 3) == 0) noise_beat(1'b0);
            end
        end

        // Let the last results drain, bounded in case the engine has hung.
        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
